// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the decompressor blocks.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lz4d_pkg.sv -----
// Shared types and constants for the LZ4 block decompressor.
// No dependencies.
package lz4d_pkg;

    localparam int HISTORY_BYTES = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_BYTES);
    localparam int LEN_W         = 18;
    localparam int CNT_W         = 17;

    localparam logic [LEN_W-1:0] LEN_MAX   = '1;
    localparam logic [3:0]       NIB_EXT   = 4'd15;
    localparam logic [7:0]       EXT_MORE  = 8'd255;
    localparam logic [7:0]       MIN_MATCH = 8'd4;
    localparam logic [CNT_W-1:0] CAP_RESET = 17'h10000;
    localparam logic [CNT_W-1:0] HIST_LIMIT = CNT_W'(HISTORY_BYTES);

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_LITEXT  = 3'd1,
        PH_LIT     = 3'd2,
        PH_OFFLO   = 3'd3,
        PH_OFFHI   = 3'd4,
        PH_MEXT    = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_TRUNC  = 3'd1,
        ERR_CAP    = 3'd2,
        ERR_OFFSET = 3'd3,
        ERR_BUSY   = 3'd4
    } t_err;

endpackage

// ----- hw/rtl/lz4_block_decompressor.sv -----
// LZ4 block decompressor: one compressed byte or drain tick per beat.
// Each beat passes stage 1 and the output register; throughput one beat per cycle
// unless i_out_ready stalls; set by the parse update and 1-read/1-write history RAM.
// A match byte read in the cycle its source is written comes from a forward path.
// Reset (synchronous, active low) clears parse state and counts and sets the
// capacity to 65536; the history RAM is not cleared and needs no clearing pass.
// Depends on lz4d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lz4_block_decompressor
    import lz4d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_copy_pending,
    output logic             o_block_end,
    output logic [CNT_W-1:0] o_produced_count,
    output logic [2:0]       o_error_code
);

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [7:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {{(LEN_W-7){1'b0}}, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    function automatic logic cap_over(input logic [CNT_W-1:0] cnt,
                                      input logic [LEN_W-1:0] len,
                                      input logic [CNT_W-1:0] cap);
        logic [LEN_W:0] s;
        s = {2'b00, cnt} + {1'b0, len};
        return s > {2'b00, cap};
    endfunction

    // parse state
    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_lit_rem, n_lit_rem;
    logic [LEN_W-1:0] r_mnib, n_mnib;
    logic [15:0]      r_moff, n_moff;
    logic [LEN_W-1:0] r_copy_rem, n_copy_rem;
    logic [CNT_W-1:0] r_out_count, n_out_count;
    logic             r_stream_ended, n_stream_ended;
    logic [CNT_W-1:0] r_cap;

    // stage 1 (history write, byte select)
    logic               r_s1_valid;
    t_kind              r_s1_kind, n_s1_kind;
    logic [7:0]         r_s1_byte, n_s1_byte;
    logic               r_s1_from_mem;
    logic               r_s1_we;
    logic [HIST_AW-1:0] r_s1_waddr;
    logic               r_s1_pend, n_s1_pend;
    logic               r_s1_end, n_s1_end;
    logic [CNT_W-1:0]   r_s1_cnt;
    t_err               r_s1_err, n_s1_err;

    // output register
    logic             r_o_valid;
    t_kind            r_o_kind;
    logic [7:0]       r_o_byte;
    logic             r_o_pend;
    logic             r_o_end;
    logic [CNT_W-1:0] r_o_cnt;
    t_err             r_o_err;

    logic [7:0]         mem_hist [HISTORY_BYTES];
    logic [7:0]         r_rdata;
    logic [HIST_AW-1:0] src_addr;
    logic [CNT_W-1:0]   src_diff;
    logic               n_put, n_rd, fwd_hit, mem_re;
    logic               accept, s1_move;
    logic [7:0]         s1_byte;

    assign s1_move    = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;
    assign s1_byte    = r_s1_from_mem ? r_rdata : r_s1_byte;

    assign src_diff = r_out_count - {1'b0, r_moff};
    assign src_addr = src_diff[HIST_AW-1:0];
    // source written by the beat leaving stage 1 this cycle: take it from there
    assign fwd_hit  = r_s1_valid && r_s1_we && (r_s1_waddr == src_addr);
    assign mem_re   = accept && n_rd && !fwd_hit;

    always_comb begin
        logic             v_fail, v_fin_lit, v_fin_match, v_restart;
        t_err             v_fcode;
        logic [LEN_W-1:0] v_mlen;
        n_phase        = r_phase;
        n_lit_rem      = r_lit_rem;
        n_mnib         = r_mnib;
        n_moff         = r_moff;
        n_copy_rem     = r_copy_rem;
        n_out_count    = r_out_count;
        n_stream_ended = r_stream_ended;
        n_s1_kind      = KIND_NONE;
        n_s1_byte      = 8'h00;
        n_s1_end       = 1'b0;
        n_s1_err       = ERR_NONE;
        n_put          = 1'b0;
        n_rd           = 1'b0;
        v_fail         = 1'b0;
        v_fcode        = ERR_NONE;
        v_fin_lit      = 1'b0;
        v_fin_match    = 1'b0;
        v_restart      = 1'b0;
        v_mlen         = '0;

        if (i_cmd) begin
            if (r_copy_rem != '0 && r_phase != PH_DISCARD) begin
                n_put      = 1'b1;
                n_rd       = 1'b1;
                n_copy_rem = r_copy_rem - 1'b1;
                if (n_copy_rem == '0 && r_stream_ended) begin
                    n_s1_end  = 1'b1;
                    v_restart = 1'b1;
                end
            end
        end else if (r_phase == PH_DISCARD) begin
            v_restart = i_in_last;
        end else if (r_copy_rem != '0) begin
            v_fail  = 1'b1;
            v_fcode = ERR_BUSY;
        end else begin
            case (r_phase)
                PH_TOKEN: begin
                    n_lit_rem = {{(LEN_W-4){1'b0}}, i_in_byte[7:4]};
                    n_mnib    = {{(LEN_W-4){1'b0}}, i_in_byte[3:0]};
                    if (i_in_byte[7:4] == NIB_EXT) begin
                        if (i_in_last) begin
                            v_fail  = 1'b1;
                            v_fcode = ERR_TRUNC;
                        end else begin
                            n_phase = PH_LITEXT;
                        end
                    end else begin
                        v_fin_lit = 1'b1;
                    end
                end
                PH_LITEXT: begin
                    n_lit_rem = sat_add(r_lit_rem, i_in_byte);
                    if (i_in_byte == EXT_MORE) begin
                        if (i_in_last) begin
                            v_fail  = 1'b1;
                            v_fcode = ERR_TRUNC;
                        end
                    end else begin
                        v_fin_lit = 1'b1;
                    end
                end
                PH_LIT: begin
                    if (i_in_last && r_lit_rem > LEN_W'(1)) begin
                        v_fail  = 1'b1;
                        v_fcode = ERR_TRUNC;
                    end else begin
                        n_put     = 1'b1;
                        n_s1_byte = i_in_byte;
                        n_lit_rem = r_lit_rem - 1'b1;
                        if (n_lit_rem == '0) begin
                            if (i_in_last) begin
                                n_s1_end  = 1'b1;
                                v_restart = 1'b1;
                            end else begin
                                n_phase = PH_OFFLO;
                            end
                        end
                    end
                end
                PH_OFFLO: begin
                    n_moff = {8'h00, i_in_byte};
                    if (i_in_last) begin
                        v_fail  = 1'b1;
                        v_fcode = ERR_TRUNC;
                    end else begin
                        n_phase = PH_OFFHI;
                    end
                end
                PH_OFFHI: begin
                    n_moff = {i_in_byte, r_moff[7:0]};
                    if (n_moff == '0 || {1'b0, n_moff} > r_out_count ||
                        {1'b0, n_moff} > HIST_LIMIT) begin
                        v_fail  = 1'b1;
                        v_fcode = ERR_OFFSET;
                    end else if (r_mnib == {{(LEN_W-4){1'b0}}, NIB_EXT}) begin
                        if (i_in_last) begin
                            v_fail  = 1'b1;
                            v_fcode = ERR_TRUNC;
                        end else begin
                            n_phase = PH_MEXT;
                        end
                    end else begin
                        v_fin_match = 1'b1;
                    end
                end
                PH_MEXT: begin
                    n_mnib = sat_add(r_mnib, i_in_byte);
                    if (i_in_byte == EXT_MORE) begin
                        if (i_in_last) begin
                            v_fail  = 1'b1;
                            v_fcode = ERR_TRUNC;
                        end
                    end else begin
                        v_fin_match = 1'b1;
                    end
                end
                default: begin
                    n_phase   = PH_DISCARD;
                    v_restart = i_in_last;
                end
            endcase
        end

        // capacity check comes before truncation
        if (v_fin_lit) begin
            if (cap_over(r_out_count, n_lit_rem, r_cap)) begin
                v_fail  = 1'b1;
                v_fcode = ERR_CAP;
            end else if (i_in_last) begin
                if (n_lit_rem != '0) begin
                    v_fail  = 1'b1;
                    v_fcode = ERR_TRUNC;
                end else begin
                    n_s1_end  = 1'b1;
                    v_restart = 1'b1;
                end
            end else begin
                n_phase = (n_lit_rem != '0) ? PH_LIT : PH_OFFLO;
            end
        end

        if (v_fin_match) begin
            v_mlen = sat_add(n_mnib, MIN_MATCH);
            if (cap_over(r_out_count, v_mlen, r_cap)) begin
                v_fail  = 1'b1;
                v_fcode = ERR_CAP;
            end else begin
                n_copy_rem     = v_mlen;
                n_stream_ended = i_in_last;
                n_phase        = PH_TOKEN;
            end
        end

        if (v_fail) begin
            n_s1_kind      = KIND_ERR;
            n_s1_err       = v_fcode;
            n_copy_rem     = '0;
            n_stream_ended = 1'b0;
            if (i_in_last) begin
                v_restart = 1'b1;
            end else begin
                n_phase = PH_DISCARD;
            end
        end

        if (n_put) begin
            n_s1_kind   = KIND_BYTE;
            n_out_count = r_out_count + 1'b1;
        end

        // copy source still in stage 1: take its byte now
        if (n_rd && fwd_hit) begin
            n_s1_byte = s1_byte;
        end

        n_s1_pend = (n_copy_rem != '0) && !v_restart;

        if (v_restart) begin
            n_phase        = PH_TOKEN;
            n_lit_rem      = '0;
            n_mnib         = '0;
            n_moff         = '0;
            n_copy_rem     = '0;
            n_out_count    = '0;
            n_stream_ended = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TOKEN;
            r_lit_rem      <= '0;
            r_mnib         <= '0;
            r_moff         <= '0;
            r_copy_rem     <= '0;
            r_out_count    <= '0;
            r_stream_ended <= 1'b0;
            r_cap          <= CAP_RESET;
            r_s1_valid     <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_phase        <= n_phase;
                r_lit_rem      <= n_lit_rem;
                r_mnib         <= n_mnib;
                r_moff         <= n_moff;
                r_copy_rem     <= n_copy_rem;
                r_out_count    <= n_out_count;
                r_stream_ended <= n_stream_ended;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // stage 1 and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind     <= n_s1_kind;
            r_s1_byte     <= n_s1_byte;
            r_s1_from_mem <= n_rd && !fwd_hit;
            r_s1_we       <= n_put;
            r_s1_waddr    <= r_out_count[HIST_AW-1:0];
            r_s1_pend     <= n_s1_pend;
            r_s1_end      <= n_s1_end;
            r_s1_cnt      <= (n_put && n_s1_end) ? r_out_count + 1'b1 :
                             (n_put ? n_out_count : r_out_count);
            r_s1_err      <= n_s1_err;
        end
        if (s1_move) begin
            r_o_kind <= r_s1_kind;
            r_o_byte <= (r_s1_kind == KIND_BYTE) ? s1_byte : 8'h00;
            r_o_pend <= r_s1_pend;
            r_o_end  <= r_s1_end;
            r_o_cnt  <= r_s1_cnt;
            r_o_err  <= r_s1_err;
        end
    end

    // history RAM: one read, one write per cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem_hist[src_addr];
        end
        if (s1_move && r_s1_we) begin
            mem_hist[r_s1_waddr] <= s1_byte;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_out_byte       = r_o_byte;
    assign o_copy_pending   = r_o_pend;
    assign o_block_end      = r_o_end;
    assign o_produced_count = r_o_cnt;
    assign o_error_code     = r_o_err;

    `CHK_IMPLY(a_copy_in_token, r_copy_rem != '0, r_phase == PH_TOKEN, "copy pending outside token phase")
    `CHK_IMPLY(a_err_code, r_o_valid && r_o_kind == KIND_ERR, r_o_err != ERR_NONE, "error beat without code")
    `CHK_IMPLY(a_end_clean, r_o_valid && r_o_end, !r_o_pend && r_o_kind != KIND_ERR, "block end with copy or error")
    `CHK_NEXT(a_s1_hold, r_s1_valid && !s1_move, r_s1_valid && $stable(r_s1_waddr), "stage 1 lost while stalled")

endmodule
